[src/lpef_pkg.sv]
// ----------------------------------------------------------------------------
// LMS prediction error filter package
// Shared widths, command and register codes, and the history port struct.
// ----------------------------------------------------------------------------
`default_nettype none

package lpef_pkg;

  // Sizes (HIST_DEPTH is a power of two, at least MAX_TAPS + MAX_DELAY)
  localparam int MAX_TAPS   = 32;
  localparam int MAX_DELAY  = 32;
  localparam int HIST_DEPTH = 64;

  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int COEF_AW = $clog2(MAX_TAPS);
  localparam int TAP_CW  = $clog2(MAX_TAPS + 1);
  localparam int DLY_W   = $clog2(MAX_DELAY + 1);

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int STEP_W   = 16;
  localparam int CFG6_W   = 6;
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 5;
  localparam int WARM_W   = 7;
  localparam int WARM_MAX = 127;

  // Shared multiplier operands: coef, err or step*err on A, sample or step on B
  localparam int MUL_AW = SAMPLE_W + STEP_W + 1;
  localparam int MUL_BW = STEP_W + 1;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_START  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRED_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = 2'd2;

  // History line port controls
  typedef struct packed {
    logic                rd_en;
    logic [HIST_AW-1:0]  rd_addr;
    logic                wr_en;
    logic [HIST_AW-1:0]  wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                clear;
  } hist_ctl_t;

endpackage

`default_nettype wire

[src/lms_prediction_error_filter_top.sv]
// ----------------------------------------------------------------------------
// LMS prediction error filter
// Sequencer, coefficient store and output register around one multiplier.
// ----------------------------------------------------------------------------
// Each sample transfer gives an error transfer e = x - sum c[k]*x[n-D-k-1];
// load and start-record transfers give none. A sample runs through one
// shared multiplier and one history read port, one tap per cycle, in a
// filter pass and, when adapting, in a second pass for the update. The
// block takes no input while a sample is at work; a finished error waits
// in the output register and the next item is accepted meanwhile.
// Coefficients keep their values across records.
`default_nettype none

module lms_prediction_error_filter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // sample[15:0], coef_index[20:16], coef_value[44:21]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // pred_error[15:0]
  output logic [1:0]       out_tuser,  // saturated[0] (error or coefficient), adapting[1]
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import lpef_pkg::*;

  localparam int ACC_W      = 48;
  localparam int CSUM_W     = COEF_W + 2;
  localparam int ERR_SHIFT  = 20;
  localparam int UPD_SHIFT  = 26;
  localparam int ERR_RND    = 1 << (ERR_SHIFT - 1);
  localparam int UPD_RND    = 1 << (UPD_SHIFT - 1);
  localparam int ERR_MAX    = 32767;
  localparam int ERR_MIN    = -32768;
  localparam int COEF_MAX   = 8388607;
  localparam int COEF_MIN   = -8388608;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_ERR,
    ST_SE,
    ST_SEW,
    ST_UPD,
    ST_WB,
    ST_OUT
  } state_t;

  // Input unpacking
  cmd_t                       in_cmd;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [IDX_W-1:0]           in_coef_index;
  logic signed [COEF_W-1:0]   in_coef_value;

  assign in_cmd        = cmd_t'(in_tuser);
  assign in_sample     = signed'(in_tdata[15:0]);
  assign in_coef_index = in_tdata[20:16];
  assign in_coef_value = signed'(in_tdata[44:21]);

  // Registers
  state_t                     state_r;
  logic [CFG6_W-1:0]          num_taps_r;
  logic [CFG6_W-1:0]          pred_delay_r;
  logic [STEP_W-1:0]          step_r;
  logic [TAP_CW-1:0]          taps_r;
  logic [DLY_W-1:0]           delay_r;
  logic [WARM_W-1:0]          warm_r;
  logic [HIST_AW-1:0]         wptr_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [SAMPLE_W-1:0] e_r;
  logic signed [MUL_AW-1:0]   se_r;
  logic                       sat_r;
  logic                       adapt_r;
  logic [TAP_CW-1:0]          cnt_r;
  logic                       p1_vld_r;
  logic [COEF_AW-1:0]         p1_idx_r;
  logic                       p2_vld_r;
  logic [COEF_AW-1:0]         p2_idx_r;
  logic signed [COEF_W-1:0]   coef_r [MAX_TAPS];
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_err_r;
  logic                       out_sat_r;
  logic                       out_adapt_r;

  // Datapath nets
  hist_ctl_t                  hist_ctl;
  logic signed [SAMPLE_W-1:0] hist_rd;
  logic                       mul_en;
  logic signed [MUL_AW-1:0]   mul_a;
  logic signed [MUL_BW-1:0]   mul_b;
  logic signed [MUL_PW-1:0]   mul_p;
  logic [COEF_AW-1:0]         coef_idx;
  logic signed [COEF_W-1:0]   coef_rd;
  logic                       issue;
  logic                       loop_done;
  logic signed [ACC_W-1:0]    e_full;
  logic signed [SAMPLE_W-1:0] e_sat;
  logic                       e_ovf;
  logic signed [MUL_PW-1:0]   upd_full;
  logic signed [CSUM_W-1:0]   c_sum;
  logic signed [COEF_W-1:0]   c_sat;
  logic                       c_ovf;
  logic                       in_xfer;
  logic                       out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_err_r;
  assign out_tuser  = {out_adapt_r, out_sat_r};
  assign out_free   = !out_valid_r || out_tready;

  // Tap loop issue and drain
  assign issue     = ((state_r == ST_FILT) || (state_r == ST_UPD)) && (cnt_r < taps_r);
  assign loop_done = (cnt_r == taps_r) && !p1_vld_r && !p2_vld_r;

  // History port: read x[n-D-k-1], write the new sample at the end
  always_comb begin
    hist_ctl.rd_en   = issue;
    hist_ctl.rd_addr = HIST_AW'(32'(wptr_r) + 2 * HIST_DEPTH - 32'(delay_r)
                                - 32'(cnt_r) - 1);
    hist_ctl.wr_en   = (state_r == ST_WB);
    hist_ctl.wr_addr = wptr_r;
    hist_ctl.wr_data = x_r;
    hist_ctl.clear   = in_xfer && (in_cmd == CMD_START);
  end

  lpef_hist_ram u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (hist_ctl),
    .rd_data_r (hist_rd)
  );

  // Coefficient read: filter reads at the multiply stage, update at write-back
  assign coef_idx = (state_r == ST_UPD) ? p2_idx_r : p1_idx_r;
  assign coef_rd  = coef_r[coef_idx];

  // Multiplier operand selection
  always_comb begin
    mul_en = p1_vld_r;
    mul_a  = MUL_AW'(coef_rd);
    mul_b  = MUL_BW'(hist_rd);
    unique case (state_r)
      ST_SE: begin
        mul_en = 1'b1;
        mul_a  = MUL_AW'(e_r);
        mul_b  = signed'({1'b0, step_r});
      end
      ST_UPD: begin
        mul_a = se_r;
      end
      default: begin
      end
    endcase
  end

  lpef_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Error: round Q.35 sum to Q1.15 and saturate
  always_comb begin
    e_full = (acc_r + ACC_W'(ERR_RND)) >>> ERR_SHIFT;
    e_ovf  = 1'b1;
    if (e_full > ACC_W'(ERR_MAX)) begin
      e_sat = SAMPLE_W'(ERR_MAX);
    end else if (e_full < ACC_W'(ERR_MIN)) begin
      e_sat = SAMPLE_W'(ERR_MIN);
    end else begin
      e_sat = SAMPLE_W'(e_full);
      e_ovf = 1'b0;
    end
  end

  // Coefficient update: round Q.46 to Q.20, add and saturate
  always_comb begin
    upd_full = (mul_p + MUL_PW'(UPD_RND)) >>> UPD_SHIFT;
    c_sum    = CSUM_W'(coef_rd) + CSUM_W'(upd_full);
    c_ovf    = 1'b1;
    if (c_sum > CSUM_W'(COEF_MAX)) begin
      c_sat = COEF_W'(COEF_MAX);
    end else if (c_sum < CSUM_W'(COEF_MIN)) begin
      c_sat = COEF_W'(COEF_MIN);
    end else begin
      c_sat = COEF_W'(c_sum);
      c_ovf = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_taps_r   <= CFG6_W'(1);
      pred_delay_r <= '0;
      step_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_TAPS:   num_taps_r   <= cfg_data[CFG6_W-1:0];
        REG_PRED_DELAY: pred_delay_r <= cfg_data[CFG6_W-1:0];
        REG_STEP_SIZE:  step_r       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Coefficient store: loads and adaptive updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (in_xfer && (in_cmd == CMD_LOAD)) begin
      if (32'(in_coef_index) < MAX_TAPS) begin
        coef_r[COEF_AW'(in_coef_index)] <= in_coef_value;
      end
    end else if ((state_r == ST_UPD) && p2_vld_r) begin
      coef_r[p2_idx_r] <= c_sat;
    end
  end

  // Tap pipeline: read issue, multiply, accumulate or write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= issue;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r <= COEF_AW'(cnt_r);
    p2_idx_r <= p1_idx_r;
  end

  // Sequencer with output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      warm_r      <= '0;
      wptr_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      adapt_r     <= 1'b0;
    end else begin
      // ST_OUT reloads the register itself when it frees up
      if (out_valid_r && out_tready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (in_cmd)
              CMD_SAMPLE: begin
                x_r     <= in_sample;
                acc_r   <= ACC_W'(in_sample) <<< ERR_SHIFT;
                taps_r  <= (32'(num_taps_r) > MAX_TAPS) ? TAP_CW'(MAX_TAPS)
                                                        : TAP_CW'(num_taps_r);
                delay_r <= (32'(pred_delay_r) > MAX_DELAY) ? DLY_W'(MAX_DELAY)
                                                           : DLY_W'(pred_delay_r);
                warm_r  <= (32'(warm_r) == WARM_MAX) ? warm_r : warm_r + 1'b1;
                cnt_r   <= '0;
                sat_r   <= 1'b0;
                state_r <= ST_FILT;
              end
              CMD_START: begin
                warm_r <= '0;
                wptr_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FILT: begin
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (p2_vld_r) begin
            acc_r <= acc_r - ACC_W'(mul_p);
          end
          if (loop_done) begin
            state_r <= ST_ERR;
          end
        end
        ST_ERR: begin
          e_r     <= e_sat;
          sat_r   <= e_ovf;
          adapt_r <= (step_r != '0) &&
                     (32'(warm_r) > 32'(taps_r) + 32'(delay_r));
          state_r <= ST_SE;
        end
        ST_SE: begin
          state_r <= adapt_r ? ST_SEW : ST_WB;
        end
        ST_SEW: begin
          se_r    <= MUL_AW'(mul_p);
          cnt_r   <= '0;
          state_r <= ST_UPD;
        end
        ST_UPD: begin
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (p2_vld_r && c_ovf) begin
            sat_r <= 1'b1;
          end
          if (loop_done) begin
            state_r <= ST_WB;
          end
        end
        ST_WB: begin
          wptr_r  <= wptr_r + 1'b1;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_err_r   <= e_r;
            out_sat_r   <= sat_r;
            out_adapt_r <= adapt_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/lpef_hist_ram.sv]
// ----------------------------------------------------------------------------
// LMS prediction error filter history line
// One write and one registered read port; per-entry valid bits make a
// cleared entry read as zero after reset or a record start.
// ----------------------------------------------------------------------------
`default_nettype none

module lpef_hist_ram (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lpef_pkg::hist_ctl_t           ctl,
  output logic signed [lpef_pkg::SAMPLE_W-1:0] rd_data_r
);
  import lpef_pkg::*;

  logic [SAMPLE_W-1:0]   mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] valid_r;

  // Sample storage
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
  end

  // Valid bits: cleared together, set on write
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      valid_r <= '0;
    end else if (ctl.wr_en) begin
      valid_r[ctl.wr_addr] <= 1'b1;
    end
  end

  // Registered read, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= valid_r[ctl.rd_addr] ? signed'(mem[ctl.rd_addr]) : '0;
    end
  end

endmodule

`default_nettype wire

[src/lpef_mul.sv]
// ----------------------------------------------------------------------------
// LMS prediction error filter shared multiplier
// Signed multiply with a registered product, time-shared by the sequencer
// between filter taps, the step*error term and coefficient updates.
// ----------------------------------------------------------------------------
`default_nettype none

module lpef_mul (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [lpef_pkg::MUL_AW-1:0] a,
  input  wire logic signed [lpef_pkg::MUL_BW-1:0] b,
  output logic signed [lpef_pkg::MUL_PW-1:0]      p_r
);
  import lpef_pkg::*;

  // Product register
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= MUL_PW'(a) * MUL_PW'(b);
    end
  end

endmodule

`default_nettype wire
